// ===== hdl/irb_pkg.sv =====
// Shared types and constants for the bilinear image rotation block.
package irb_pkg;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_CCOL   = 3'd2,
    REG_CROW   = 3'd3,
    REG_COS    = 3'd4,
    REG_SIN    = 3'd5
  } reg_idx_t;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam int PIX_W     = 24;

  // frame store size and fixed-point format
  localparam int MAX_COLS  = 256;
  localparam int MAX_ROWS  = 256;
  localparam int FRAC_BITS = 14;

  typedef logic [PIX_W-1:0] pixel_t;

endpackage

// ===== hdl/irb_bank.sv =====
// One bank of the frame store: one write port, one registered read port.
module irb_bank #(
  parameter int ADDR_W = 14
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  irb_pkg::pixel_t      wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output irb_pkg::pixel_t      rd_data
);
  import irb_pkg::*;

  pixel_t mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ===== hdl/image_rotate_bilinear.sv =====
// Top level of the bilinear image rotation block.
// Pipeline: a query result passes through seven register stages, the last being
// the output register; loads give no result.
// Throughput: one item per cycle; the whole pipe stalls only while a result waits.
// Four store banks (even/odd column x even/odd row) deliver the 2x2 patch in one read.
// Reset: synchronous, clears valid bits and restores register defaults; the frame
// store is not cleared and holds garbage until loaded.
module image_rotate_bilinear (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [7:0]                    col,
  input  logic [7:0]                    row,
  input  logic [7:0]                    red_in,
  input  logic [7:0]                    green_in,
  input  logic [7:0]                    blue_in,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    red_out,
  output logic [7:0]                    green_out,
  output logic [7:0]                    blue_out,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [irb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);
  import irb_pkg::*;

  localparam int CW   = $clog2(MAX_COLS);
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int BCW  = CW - 1;          // column bits inside a bank
  localparam int BRW  = RW - 1;
  localparam int BAW  = BCW + BRW;
  localparam int ONE  = 1 << FRAC_BITS;
  // product of 16-bit coefficient and 9-bit signed offset
  localparam int PW   = 26;
  // source position: sum of two products plus center, with headroom
  localparam int SW   = 28;
  localparam int IW   = SW - FRAC_BITS;  // integer part width
  localparam int WW   = FRAC_BITS + 1;   // single weight 0..ONE
  localparam int W2   = 2 * WW;          // combined weight
  localparam int AW   = 2 * FRAC_BITS + 10;

  // ---------------- configuration registers ----------------
  logic [8:0]         width_in_use, height_in_use;
  logic [7:0]         center_col, center_row;
  logic signed [15:0] cos_term, sin_term;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use  <= 9'd256;
      height_in_use <= 9'd256;
      center_col    <= 8'd128;
      center_row    <= 8'd128;
      cos_term      <= 16'sd16384;
      sin_term      <= 16'sd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  width_in_use  <= cfg_data[8:0];
        REG_HEIGHT: height_in_use <= cfg_data[8:0];
        REG_CCOL:   center_col    <= cfg_data[7:0];
        REG_CROW:   center_row    <= cfg_data[7:0];
        REG_COS:    cos_term      <= cfg_data;
        REG_SIN:    sin_term      <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective limits, clamped to the store size
  logic [12:0] w_eff, h_eff;
  assign w_eff = ({4'd0, width_in_use} > 13'(MAX_COLS)) ? 13'(MAX_COLS)
                                                        : {4'd0, width_in_use};
  assign h_eff = ({4'd0, height_in_use} > 13'(MAX_ROWS)) ? 13'(MAX_ROWS)
                                                         : {4'd0, height_in_use};

  // ---------------- pipeline control ----------------
  // The whole pipe advances together; the output register is the last stage.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 1: offsets from center
  logic              v1, q1;
  logic signed [8:0] dx1, dy1;
  logic [7:0]        ld_col1, ld_row1;
  pixel_t            ld_pix1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q1      <= (op == OP_QUERY);
      dx1     <= $signed({1'b0, col}) - $signed({1'b0, center_col});
      dy1     <= $signed({1'b0, row}) - $signed({1'b0, center_row});
      ld_col1 <= col;
      ld_row1 <= row;
      ld_pix1 <= {red_in, green_in, blue_in};
    end
  end

  // Store write happens from stage 1 (loads only); earlier queries already read.
  logic ld_ok;
  assign ld_ok = v1 && !q1 && adv &&
                 ({5'd0, ld_col1} < 13'(MAX_COLS)) && ({5'd0, ld_row1} < 13'(MAX_ROWS));

  // Stage 2: four products
  logic                 v2;
  logic signed [PW-1:0] pcx2, psy2, psx2, pcy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1 && q1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pcx2 <= PW'(cos_term * dx1);
      psy2 <= PW'(sin_term * dy1);
      psx2 <= PW'(sin_term * dx1);
      pcy2 <= PW'(cos_term * dy1);
    end
  end

  // Stage 3: source position, split and range check, bank addresses
  logic                   v3, in3;
  logic signed [SW-1:0]   sx, sy;
  logic signed [IW-1:0]   ix, iy;
  logic [FRAC_BITS-1:0]   fx3, fy3;
  logic                   in_img;

  always_comb begin
    sx = SW'(pcx2) - SW'(psy2) + (SW'(center_col) <<< FRAC_BITS);
    sy = SW'(psx2) + SW'(pcy2) + (SW'(center_row) <<< FRAC_BITS);
    ix = sx[SW-1:FRAC_BITS];   // arithmetic floor
    iy = sy[SW-1:FRAC_BITS];
    in_img = (ix >= 0) && (iy >= 0) &&
             (ix + IW'(1) < $signed({1'b0, w_eff})) &&
             (iy + IW'(1) < $signed({1'b0, h_eff}));
  end

  // neighbor columns/rows and bank addresses
  logic [CW-1:0]  cx0, cx1;
  logic [RW-1:0]  ry0, ry1;
  logic [BCW-1:0] ce_a, co_a;  // even/odd column index in bank
  logic [BRW-1:0] re_a, ro_a;

  always_comb begin
    cx0 = ix[CW-1:0];
    cx1 = cx0 + CW'(1);
    ry0 = iy[RW-1:0];
    ry1 = ry0 + RW'(1);
    ce_a = cx0[0] ? cx1[CW-1:1] : cx0[CW-1:1];
    co_a = cx0[0] ? cx0[CW-1:1] : cx1[CW-1:1];
    re_a = ry0[0] ? ry1[RW-1:1] : ry0[RW-1:1];
    ro_a = ry0[0] ? ry0[RW-1:1] : ry1[RW-1:1];
  end

  logic xodd3, yodd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in3   <= in_img;
      fx3   <= sx[FRAC_BITS-1:0];
      fy3   <= sy[FRAC_BITS-1:0];
      xodd3 <= cx0[0];
      yodd3 <= ry0[0];
    end
  end

  // frame store: four banks by column and row parity
  pixel_t          bank_q [4];
  logic [BAW-1:0]  wa;
  logic [1:0]      wsel;
  assign wa   = {ld_row1[RW-1:1], ld_col1[CW-1:1]};
  assign wsel = {ld_row1[0], ld_col1[0]};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [BAW-1:0] ra;
    assign ra = {((b / 2) == 1 ? ro_a : re_a), ((b % 2) == 1 ? co_a : ce_a)};
    irb_bank #(.ADDR_W(BAW)) u_bank (
      .clk     (clk),
      .wr_en   (ld_ok && (wsel == 2'(b))),
      .wr_addr (wa),
      .wr_data (ld_pix1),
      .rd_en   (adv),
      .rd_addr (ra),
      .rd_data (bank_q[b])
    );
  end

  // Stage 4: unscramble banks, compute single weights
  logic            v4, in4;
  pixel_t          p00, p10, p01, p11;
  logic [WW-1:0]   wx0, wx1, wy0, wy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in4 <= in3;
      p00 <= bank_q[{yodd3, xodd3}];
      p10 <= bank_q[{yodd3, !xodd3}];
      p01 <= bank_q[{!yodd3, xodd3}];
      p11 <= bank_q[{!yodd3, !xodd3}];
      wx1 <= {1'b0, fx3};
      wx0 <= WW'(ONE) - {1'b0, fx3};
      wy1 <= {1'b0, fy3};
      wy0 <= WW'(ONE) - {1'b0, fy3};
    end
  end

  // Stage 5: 2-D weights
  logic            v5, in5;
  pixel_t          p00_5, p10_5, p01_5, p11_5;
  logic [W2-1:0]   w00, w10, w01, w11;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in5   <= in4;
      p00_5 <= p00;
      p10_5 <= p10;
      p01_5 <= p01;
      p11_5 <= p11;
      w00   <= wx0 * wy0;
      w10   <= wx1 * wy0;
      w01   <= wx0 * wy1;
      w11   <= wx1 * wy1;
    end
  end

  // Stage 6: weight times channel, per channel and corner
  logic          v6, in6;
  logic [AW-1:0] prod [3][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in6 <= in5;
      for (int k = 0; k < 3; k++) begin
        prod[k][0] <= AW'(w00 * p00_5[16-8*k +: 8]);
        prod[k][1] <= AW'(w10 * p10_5[16-8*k +: 8]);
        prod[k][2] <= AW'(w01 * p01_5[16-8*k +: 8]);
        prod[k][3] <= AW'(w11 * p11_5[16-8*k +: 8]);
      end
    end
  end

  // Stage 7 (output register): sum, truncate, black outside the image
  logic [AW-1:0] acc [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = prod[k][0] + prod[k][1] + prod[k][2] + prod[k][3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_out   <= in6 ? acc[0][2*FRAC_BITS +: 8] : 8'd0;
      green_out <= in6 ? acc[1][2*FRAC_BITS +: 8] : 8'd0;
      blue_out  <= in6 ? acc[2][2*FRAC_BITS +: 8] : 8'd0;
    end
  end

endmodule
